// ===== hdl/bpg_pkg.sv =====
// ----------------------------------------------------------------------------
// bpg_pkg
// shared types and constants of the bezier path point generator
// ----------------------------------------------------------------------------
package bpg_pkg;

    // defaults of the top level parameters
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;

    // configuration register widths and reset values
    localparam int NPTS_BITS = 7;
    localparam int FRAC_BITS = 17;
    localparam logic [NPTS_BITS-1:0] NPTS_RESET  = 7'd16;
    localparam logic [FRAC_BITS-1:0] FRAC1_RESET = 17'd16384;
    localparam logic [FRAC_BITS-1:0] FRAC2_RESET = 17'd49152;
    localparam logic [NPTS_BITS-1:0] NPTS_MIN    = 7'd2;

    // q1.16 fixed point
    localparam int Q_SHIFT = 16;
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'd65536;

    // bernstein weights are q.48, split in a high and a low part
    localparam int WEIGHT_BITS = 49;
    localparam int WSPLIT      = 24;

    // step divider: dividend 2^17, divisor 2*(n-1)
    localparam int DIV_BITS  = 18;
    localparam int DVSR_BITS = 7;

    // apb port
    localparam int ADDR_BITS     = 4;
    localparam int APB_DATA_BITS = 32;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_POINTS = 2'd0;
    localparam logic [1:0] REG_FRAC1  = 2'd1;
    localparam logic [1:0] REG_FRAC2  = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CTRL_MUL,
        SEQ_CTRL_TRUNC,
        SEQ_RUN
    } t_seq_state;

    // one curve parameter handed to the evaluation pipeline
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [FRAC_BITS-1:0] t;
    } t_issue;

endpackage

// ===== hdl/bpg_step_div.sv =====
// ----------------------------------------------------------------------------
// bpg_step_div
// radix-2 restoring divider for the curve parameter step 2^17 / divisor
// ----------------------------------------------------------------------------
module bpg_step_div
    import bpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVSR_BITS-1:0] i_divisor,
    output logic                 o_busy,
    output logic [FRAC_BITS-1:0] o_quotient,
    output logic [DVSR_BITS-1:0] o_remainder
);

    localparam int CNT_BITS = $clog2(DIV_BITS);
    localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(1) << (DIV_BITS - 1);

    logic                 r_busy;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DVSR_BITS-1:0] r_rem;
    logic [FRAC_BITS-1:0] r_quo;

    logic [DVSR_BITS:0]   w_trial;
    logic                 w_fit;
    logic [DVSR_BITS-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, DIVIDEND[r_cnt]};
        w_fit   = (w_trial >= {1'b0, i_divisor});
        if (w_fit) begin
            n_rem = DVSR_BITS'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = DVSR_BITS'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(DIV_BITS - 1);
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[FRAC_BITS-2:0], w_fit};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/bpg_eval_pipe.sv =====
// ----------------------------------------------------------------------------
// bpg_eval_pipe
// seven stage pipeline evaluating one cubic bezier point per cycle while i_adv is high
// ----------------------------------------------------------------------------
module bpg_eval_pipe
    import bpg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  t_issue                           i_issue,
    // control points, [axis][point], axis 0 is x
    input  logic [1:0][3:0][COORD_BITS-1:0]  i_pts,
    output logic                             o_front_busy,
    output logic                             o_valid,
    output logic [COORD_BITS-1:0]            o_point_x,
    output logic [COORD_BITS-1:0]            o_point_y,
    output logic                             o_last
);

    localparam int HI_BITS   = WEIGHT_BITS - WSPLIT;
    localparam int LO_BITS   = WSPLIT;
    localparam int HP_BITS   = COORD_BITS + HI_BITS + 1;
    localparam int LP_BITS   = COORD_BITS + LO_BITS + 1;
    localparam int HS_BITS   = HP_BITS + 2;
    localparam int LS_BITS   = LP_BITS + 2;
    localparam int SUM_BITS  = HS_BITS + WSPLIT;
    localparam int OUT_SHIFT = 3 * Q_SHIFT;
    localparam int SQ_BITS   = 2 * FRAC_BITS;
    localparam int CU_BITS   = 3 * FRAC_BITS;
    localparam logic [SUM_BITS-1:0] HALF = SUM_BITS'(1) << (OUT_SHIFT - 1);

    // valid bits
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic r1_last, r2_last, r3_last, r4_last, r5_last, r6_last, r7_last;

    // stage payloads
    logic [FRAC_BITS-1:0]         r1_t, r1_u, r2_t, r2_u;
    logic [SQ_BITS-1:0]           r2_t2, r2_u2;
    logic [WEIGHT_BITS-1:0]       r3_w [4];
    logic signed [HP_BITS-1:0]    r4_hp [2][4];
    logic signed [LP_BITS-1:0]    r4_lp [2][4];
    logic signed [HS_BITS-1:0]    r5_hs [2];
    logic signed [LS_BITS-1:0]    r5_ls [2];
    logic signed [SUM_BITS-1:0]   r6_s [2];
    logic [COORD_BITS-1:0]        r7_pt [2];

    logic [CU_BITS-1:0]           w_m0, w_m1, w_m2, w_m3;
    logic [WEIGHT_BITS-1:0]       n_w [4];
    logic signed [HP_BITS-1:0]    n_hp [2][4];
    logic signed [LP_BITS-1:0]    n_lp [2][4];
    logic [SUM_BITS-1:0]          n_rnd [2];

    // weights: u^3, 3u^2t, 3ut^2, t^3
    always_comb begin
        w_m0 = r2_u2 * r2_u;
        w_m1 = r2_u2 * r2_t;
        w_m2 = r2_t2 * r2_u;
        w_m3 = r2_t2 * r2_t;
        n_w[0] = WEIGHT_BITS'(w_m0);
        n_w[1] = WEIGHT_BITS'(w_m1 + (w_m1 << 1));
        n_w[2] = WEIGHT_BITS'(w_m2 + (w_m2 << 1));
        n_w[3] = WEIGHT_BITS'(w_m3);
    end

    // partial products of weight halves and coordinates
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 4; k++) begin
                n_hp[a][k] = $signed(i_pts[a][k])
                           * $signed({1'b0, r3_w[k][WEIGHT_BITS-1:WSPLIT]});
                n_lp[a][k] = $signed(i_pts[a][k])
                           * $signed({1'b0, r3_w[k][WSPLIT-1:0]});
            end
        end
    end

    // round half away from zero: floor((s + half - neg) / 2^48)
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_rnd[a] = r6_s[a] + HALF - SUM_BITS'(r6_s[a][SUM_BITS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_issue.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_t    <= i_issue.t;
            r1_u    <= FRAC_ONE - i_issue.t;
            r1_last <= i_issue.last;

            r2_t    <= r1_t;
            r2_u    <= r1_u;
            r2_t2   <= r1_t * r1_t;
            r2_u2   <= r1_u * r1_u;
            r2_last <= r1_last;

            r3_w    <= n_w;
            r3_last <= r2_last;

            r4_hp   <= n_hp;
            r4_lp   <= n_lp;
            r4_last <= r3_last;

            for (int a = 0; a < 2; a++) begin
                r5_hs[a] <= HS_BITS'(r4_hp[a][0]) + HS_BITS'(r4_hp[a][1])
                          + HS_BITS'(r4_hp[a][2]) + HS_BITS'(r4_hp[a][3]);
                r5_ls[a] <= LS_BITS'(r4_lp[a][0]) + LS_BITS'(r4_lp[a][1])
                          + LS_BITS'(r4_lp[a][2]) + LS_BITS'(r4_lp[a][3]);
                r6_s[a]  <= (SUM_BITS'(r5_hs[a]) <<< WSPLIT) + SUM_BITS'(r5_ls[a]);
                r7_pt[a] <= n_rnd[a][OUT_SHIFT +: COORD_BITS];
            end
            r5_last <= r4_last;
            r6_last <= r5_last;
            r7_last <= r6_last;
        end
    end

    // stages whose next step still reads the control points
    assign o_front_busy = r1_v | r2_v | r3_v;
    assign o_valid      = r7_v;
    assign o_point_x    = r7_pt[0];
    assign o_point_y    = r7_pt[1];
    assign o_last       = r7_last;

endmodule

// ===== hdl/bezier_path_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// bezier_path_point_generator_top
// cubic bezier path point generator with apb configuration
// ----------------------------------------------------------------------------
// usage
// - slave stream: one word carries start x/y and end x/y of a curve
// - master stream: one word per curve point (x, y), tlast on the final point
// - apb: points per curve, first and second control fraction (q1.16)
// - the two inner control points lie on the start-end segment; they are
//   formed in the multiply and truncate states after the input word is taken
// - throughput: one point per cycle while the receiver does not stall; the
//   next input word is taken once the point sequencer has issued every point
//   and the three pipeline stages that still read the control points are empty
// - the point parameter t advances by a quotient and remainder from a
//   serial divider; it runs after reset and after each write of points per
//   curve, and no input word is taken meanwhile
// - reset: registers return to 16 points and fractions 0.25 / 0.75, the
//   pipeline empties and the divider starts
// - receiver stall: m_axis_tready low while a point waits at the output
//   freezes the whole point pipeline; nothing is lost or repeated
// ----------------------------------------------------------------------------
module bezier_path_point_generator_top
    import bpg_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // apb configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ADDR_BITS-1:0]                 paddr,
    input  logic [APB_DATA_BITS-1:0]             pwdata,
    output logic [APB_DATA_BITS-1:0]             prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y (lowest bits first), zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: point_x, point_y (lowest bits first), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // tlast: last_point
    output logic                                 m_axis_tlast
);

    localparam int OUT_BITS = ((2*COORD_BITS+7)/8)*8;
    localparam int J_BITS   = $clog2(MAX_POINTS);
    localparam int NUM_BITS = COORD_BITS + 20;
    localparam logic [NPTS_BITS-1:0] NPTS_MAX = NPTS_BITS'(MAX_POINTS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [NPTS_BITS-1:0] r_ppc;
    logic [FRAC_BITS-1:0] r_f1;
    logic [FRAC_BITS-1:0] r_f2;
    logic                 w_cfg_wr;
    logic [1:0]           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppc <= NPTS_RESET;
            r_f1  <= FRAC1_RESET;
            r_f2  <= FRAC2_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_POINTS: begin
                    r_ppc <= pwdata[NPTS_BITS-1:0];
                end
                REG_FRAC1: begin
                    r_f1 <= pwdata[FRAC_BITS-1:0];
                end
                REG_FRAC2: begin
                    r_f2 <= pwdata[FRAC_BITS-1:0];
                end
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_POINTS: prdata = APB_DATA_BITS'(r_ppc);
            REG_FRAC1:  prdata = APB_DATA_BITS'(r_f1);
            REG_FRAC2:  prdata = APB_DATA_BITS'(r_f2);
            default:    prdata = '0;
        endcase
    end

    // saturated point count and fractions
    logic [NPTS_BITS-1:0] w_n_eff;
    logic [NPTS_BITS-1:0] w_n_last;
    logic [FRAC_BITS-1:0] w_frac [2];
    logic [DVSR_BITS-1:0] w_divisor;

    always_comb begin
        if (r_ppc < NPTS_MIN) begin
            w_n_eff = NPTS_MIN;
        end else if (r_ppc > NPTS_MAX) begin
            w_n_eff = NPTS_MAX;
        end else begin
            w_n_eff = r_ppc;
        end
        w_n_last  = w_n_eff - 1'b1;
        // 2*(n-1), at most 2*(MAX_POINTS-1)
        w_divisor = {w_n_last[DVSR_BITS-2:0], 1'b0};
        w_frac[0] = (r_f1 > FRAC_ONE) ? FRAC_ONE : r_f1;
        w_frac[1] = (r_f2 > FRAC_ONE) ? FRAC_ONE : r_f2;
    end

    // ------------------------------------------------------------------
    // step divider: t advances by 2^17 / (2(n-1)) per point
    // ------------------------------------------------------------------
    logic                 w_div_busy;
    logic [FRAC_BITS-1:0] w_div_q;
    logic [DVSR_BITS-1:0] w_div_r;

    bpg_step_div u_step_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_cfg_wr && (w_cfg_idx == REG_POINTS)),
        .i_divisor   (w_divisor),
        .o_busy      (w_div_busy),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    t_seq_state r_state;
    t_seq_state n_state;

    logic                 w_adv;
    logic                 w_front_busy;
    logic                 w_pipe_valid;
    logic                 w_in_acc;
    logic                 w_is_last;
    logic                 w_do_mul;
    logic                 w_do_trunc;
    logic                 w_step;
    t_issue               w_issue;

    logic [J_BITS-1:0]    r_j;
    logic [FRAC_BITS-1:0] r_q;
    logic [DVSR_BITS-1:0] r_r;
    logic [DVSR_BITS:0]   w_rsum;

    assign w_adv     = !w_pipe_valid || m_axis_tready;
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_is_last = (NPTS_BITS'(r_j) == w_n_last);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (w_in_acc) begin
                    n_state = SEQ_CTRL_MUL;
                end
            end
            SEQ_CTRL_MUL: begin
                n_state = SEQ_CTRL_TRUNC;
            end
            SEQ_CTRL_TRUNC: begin
                n_state = SEQ_RUN;
            end
            SEQ_RUN: begin
                if (w_adv && w_is_last) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_do_mul      = 1'b0;
        w_do_trunc    = 1'b0;
        w_step        = 1'b0;
        w_issue.valid = 1'b0;
        w_issue.last  = w_is_last;
        w_issue.t     = r_q;
        unique case (r_state)
            SEQ_IDLE: begin
                // new curve only once the divider is idle and earlier points no longer read the points
                s_axis_tready = !w_div_busy && !w_front_busy;
            end
            SEQ_CTRL_MUL: begin
                w_do_mul = 1'b1;
            end
            SEQ_CTRL_TRUNC: begin
                w_do_trunc = 1'b1;
            end
            SEQ_RUN: begin
                w_issue.valid = 1'b1;
                w_step        = w_adv;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // t = floor((j*2^17 + n-1) / 2(n-1)) kept as quotient and remainder
    assign w_rsum = {1'b0, r_r} + {1'b0, w_div_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
            r_q <= '0;
            r_r <= '0;
        end else if (w_do_trunc) begin
            r_j <= '0;
            r_q <= '0;
            r_r <= w_n_last[DVSR_BITS-1:0];
        end else if (w_step) begin
            r_j <= r_j + 1'b1;
            if (w_rsum >= {1'b0, w_divisor}) begin
                r_r <= DVSR_BITS'(w_rsum - {1'b0, w_divisor});
                r_q <= FRAC_BITS'(r_q + w_div_q + 1'b1);
            end else begin
                r_r <= DVSR_BITS'(w_rsum);
                r_q <= FRAC_BITS'(r_q + w_div_q);
            end
        end
    end

    // ------------------------------------------------------------------
    // held coordinates and control points, [axis][point]
    // point 0 start, 1 first control, 2 second control, 3 end
    // ------------------------------------------------------------------
    logic [1:0][3:0][COORD_BITS-1:0] r_pts;
    logic signed [NUM_BITS-1:0]      r_num [2][2];
    logic signed [COORD_BITS:0]      w_diff [2];
    logic signed [NUM_BITS-1:0]      n_num [2][2];
    logic [NUM_BITS-1:0]             w_trq [2][2];

    // c = trunc((a*2^16 + (b-a)*f) / 2^16) toward zero
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_diff[a] = $signed(r_pts[a][3]) - $signed(r_pts[a][0]);
            for (int c = 0; c < 2; c++) begin
                n_num[a][c] = (NUM_BITS'($signed(r_pts[a][0])) <<< Q_SHIFT)
                            + NUM_BITS'(w_diff[a]) * $signed({1'b0, w_frac[c]});
                w_trq[a][c] = r_num[a][c]
                            + NUM_BITS'({Q_SHIFT{r_num[a][c][NUM_BITS-1]}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pts[0][0] <= s_axis_tdata[0 +: COORD_BITS];
            r_pts[1][0] <= s_axis_tdata[COORD_BITS +: COORD_BITS];
            r_pts[0][3] <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
            r_pts[1][3] <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        end
        if (w_do_mul) begin
            r_num <= n_num;
        end
        if (w_do_trunc) begin
            for (int a = 0; a < 2; a++) begin
                r_pts[a][1] <= w_trq[a][0][Q_SHIFT +: COORD_BITS];
                r_pts[a][2] <= w_trq[a][1][Q_SHIFT +: COORD_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // point evaluation pipeline and output word
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] w_point_x;
    logic [COORD_BITS-1:0] w_point_y;
    logic                  w_point_last;

    bpg_eval_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_eval_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_issue      (w_issue),
        .i_pts        (r_pts),
        .o_front_busy (w_front_busy),
        .o_valid      (w_pipe_valid),
        .o_point_x    (w_point_x),
        .o_point_y    (w_point_y),
        .o_last       (w_point_last)
    );

    assign m_axis_tvalid = w_pipe_valid;
    assign m_axis_tdata  = OUT_BITS'({w_point_y, w_point_x});
    assign m_axis_tlast  = w_point_last;

endmodule
